/* rtl/core/css_pkg.sv */
// Shared types, constants and helpers for the caseless substring search.
// Used by every module of the block; depends on nothing.
`default_nettype none

package css_pkg;

  localparam int NEEDLE_MAX_DEF   = 32;
  localparam int HAYSTACK_MAX_DEF = 65535;
  localparam int QUEUE_DEPTH      = 4;

  localparam int BYTE_W    = 8;
  localparam int WORD_W    = 64;
  localparam int CFG_IDX_W = 3;
  localparam int LEN_CFG_W = 6;
  localparam int COUNT_W   = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_WORD_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_WORD_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_WORD_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_WORD_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LENGTH = 3'd4;

  typedef struct packed {
    logic               found;
    logic [COUNT_W-1:0] offset;
    logic               too_long;
  } css_result_t;

  // Fold ASCII upper case to lower case; everything else passes unchanged.
  function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/css_front.sv */
// Front end: needle configuration registers, byte folding and per-position compare.
// Depends on css_pkg.
`default_nettype none

module css_front #(
  parameter int NEEDLE_MAX = css_pkg::NEEDLE_MAX_DEF,
  parameter int LW         = $clog2(NEEDLE_MAX + 1)
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  input  wire logic [css_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [css_pkg::WORD_W-1:0]     cfg_data,
  input  wire logic [css_pkg::BYTE_W-1:0]     hay_byte,
  output logic      [NEEDLE_MAX-1:0]          eq_vec,
  output logic      [LW-1:0]                  len_r
);
  import css_pkg::*;

  logic [NEEDLE_MAX-1:0][BYTE_W-1:0] needle_r;
  logic [LEN_CFG_W-1:0]              len_raw;
  logic [LW-1:0]                     len_nxt;
  logic [BYTE_W-1:0]                 hay_fold;

  assign len_raw = cfg_data[LEN_CFG_W-1:0];
  assign len_nxt = (len_raw > LEN_CFG_W'(NEEDLE_MAX)) ? LW'(NEEDLE_MAX) : LW'(len_raw);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needle_r <= '0;
      len_r    <= '0;
    end else if (cfg_valid) begin
      // each needle byte belongs to word i/8, lane i%8
      for (int i = 0; i < NEEDLE_MAX; i++) begin
        if (cfg_index == CFG_IDX_W'(i >> 3)) begin
          needle_r[i] <= cfg_data[(i & 7) * BYTE_W +: BYTE_W];
        end
      end
      if (cfg_index == CFG_NEEDLE_LENGTH) begin
        len_r <= len_nxt;
      end
    end
  end

  assign hay_fold = fold_byte(hay_byte);

  always_comb begin
    for (int i = 0; i < NEEDLE_MAX; i++) begin
      eq_vec[i] = (fold_byte(needle_r[i]) == hay_fold);
    end
  end

endmodule

`default_nettype wire

/* rtl/core/css_queue.sv */
// Small flop-based queue between the front and back ends.
// Depends on css_pkg only for the default queue depth.
`default_nettype none

module css_queue #(
  parameter int WIDTH = 33,
  parameter int DEPTH = css_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output logic                  empty
);
  localparam int AW = $clog2(DEPTH);

  logic [DEPTH-1:0][WIDTH-1:0] mem_r;
  logic [AW-1:0]               wptr_r;
  logic [AW-1:0]               rptr_r;
  logic [AW:0]                 cnt_r;
  logic                        do_push;
  logic                        do_pop;

  assign full     = (cnt_r == (AW+1)'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= wptr_r + AW'(1);
      end
      if (do_pop) begin
        rptr_r <= rptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - (AW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/css_back.sv */
// Back end: partial-match vector, byte count, first-match capture and result register.
// Depends on css_pkg.
`default_nettype none

module css_back #(
  parameter int NEEDLE_MAX   = css_pkg::NEEDLE_MAX_DEF,
  parameter int HAYSTACK_MAX = css_pkg::HAYSTACK_MAX_DEF,
  parameter int LW           = $clog2(NEEDLE_MAX + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [LW-1:0]         len,
  input  wire logic                  q_empty,
  input  wire logic [NEEDLE_MAX:0]   q_data,
  output logic                       q_pop,
  input  wire logic                  res_pop,
  output logic                       res_valid,
  output css_pkg::css_result_t       res
);
  import css_pkg::*;

  localparam int NW = $clog2(NEEDLE_MAX);

  logic [NEEDLE_MAX-1:0] pm_r, pm_nxt, lenmask;
  logic [COUNT_W-1:0]    count_r, count_nxt;
  logic [COUNT_W-1:0]    first_r, first_nxt;
  logic                  seen_r, seen_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  ovalid_r;
  css_result_t           res_r, res_nxt;
  logic [NEEDLE_MAX-1:0] eq;
  logic                  last;
  logic [LW-1:0]         len_m1;
  logic                  hit;
  logic                  take;

  assign eq     = q_data[NEEDLE_MAX-1:0];
  assign last   = q_data[NEEDLE_MAX];
  assign len_m1 = len - LW'(1);

  always_comb begin
    for (int i = 0; i < NEEDLE_MAX; i++) begin
      lenmask[i] = (LW'(i) < len);
    end
  end

  // a finished result holds the back end only when it would be overwritten
  assign q_pop = !q_empty && (!last || !ovalid_r || res_pop);
  assign take  = q_pop;

  always_comb begin
    pm_nxt    = pm_r;
    count_nxt = count_r;
    first_nxt = first_r;
    seen_nxt  = seen_r;
    ovf_nxt   = ovf_r;
    hit       = 1'b0;
    if (count_r >= COUNT_W'(HAYSTACK_MAX)) begin
      ovf_nxt = 1'b1;
    end else begin
      pm_nxt = {pm_r[NEEDLE_MAX-2:0], 1'b1} & eq & lenmask;
      hit    = (len != '0) && pm_nxt[len_m1[NW-1:0]];
      if (hit && !seen_r) begin
        seen_nxt  = 1'b1;
        first_nxt = count_r + COUNT_W'(1) - COUNT_W'(len);
      end
      count_nxt = count_r + COUNT_W'(1);
    end
    res_nxt.found    = (len == '0) || seen_nxt;
    res_nxt.offset   = ((len != '0) && seen_nxt) ? first_nxt : '0;
    res_nxt.too_long = ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pm_r     <= '0;
      count_r  <= '0;
      first_r  <= '0;
      seen_r   <= 1'b0;
      ovf_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (take && last) begin
        ovalid_r <= 1'b1;
      end else if (res_pop && ovalid_r) begin
        ovalid_r <= 1'b0;
      end
      if (take) begin
        if (last) begin
          // clear the search for the next haystack
          pm_r     <= '0;
          count_r  <= '0;
          first_r  <= '0;
          seen_r   <= 1'b0;
          ovf_r    <= 1'b0;
        end else begin
          pm_r    <= pm_nxt;
          count_r <= count_nxt;
          first_r <= first_nxt;
          seen_r  <= seen_nxt;
          ovf_r   <= ovf_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && last) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = ovalid_r;
  assign res       = res_r;

endmodule

`default_nettype wire

/* rtl/core/caseless_substring_search.sv */
// Top level of the caseless substring search: front end, item queue, back end.
// Depends on css_pkg, css_front, css_queue and css_back.
//
//   channel  ports                                    accepted when
//   in       in_push/in_full, haystack byte, is_last  in_push && !in_full
//   out      out_pop/out_empty, found, offset, flag   out_pop && !out_empty
//   cfg      cfg_valid/cfg_ready, index, data         cfg_valid && cfg_ready
//
// One haystack byte per cycle is taken while in_full is low; each byte is folded
// and compared against all needle positions in the cycle it is accepted; the
// partial-match vector advances one byte per cycle in the back end unless
// stalled. A result is registered as its last byte leaves the queue. Synchronous
// reset clears the search and needle. A pending result stalls the back end only
// at the next last byte; the four-entry queue then fills and raises in_full.
`default_nettype none

module caseless_substring_search #(
  parameter int NEEDLE_MAX   = css_pkg::NEEDLE_MAX_DEF,
  parameter int HAYSTACK_MAX = css_pkg::HAYSTACK_MAX_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic [css_pkg::BYTE_W-1:0]    in_haystack_byte,
  input  wire logic                          in_is_last,
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic                               out_found,
  output logic      [css_pkg::COUNT_W-1:0]   out_match_offset,
  output logic                               out_too_long,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [css_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [css_pkg::WORD_W-1:0]    cfg_data
);
  import css_pkg::*;

  localparam int LW = $clog2(NEEDLE_MAX + 1);

  logic [NEEDLE_MAX-1:0] eq_vec;
  logic [LW-1:0]         len;
  logic [NEEDLE_MAX:0]   q_data;
  logic                  q_empty;
  logic                  q_pop;
  logic                  res_valid;
  css_result_t           res;

  assign cfg_ready = 1'b1;

  css_front #(
    .NEEDLE_MAX (NEEDLE_MAX),
    .LW         (LW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .hay_byte  (in_haystack_byte),
    .eq_vec    (eq_vec),
    .len_r     (len)
  );

  css_queue #(
    .WIDTH (NEEDLE_MAX + 1),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .push_data ({in_is_last, eq_vec}),
    .full      (in_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  css_back #(
    .NEEDLE_MAX   (NEEDLE_MAX),
    .HAYSTACK_MAX (HAYSTACK_MAX),
    .LW           (LW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .len       (len),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .res_pop   (out_pop),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_empty        = !res_valid;
  assign out_found        = res.found;
  assign out_match_offset = res.offset;
  assign out_too_long     = res.too_long;

endmodule

`default_nettype wire

/* rtl/core/css_checker.sv */
// Port-level checks for caseless_substring_search, bound to the top level.
// Depends on css_pkg for port widths.
`default_nettype none

module css_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_push,
  input wire logic                          in_full,
  input wire logic                          out_empty,
  input wire logic                          out_pop,
  input wire logic                          out_found,
  input wire logic [css_pkg::COUNT_W-1:0]   out_match_offset,
  input wire logic                          out_too_long,
  input wire logic                          cfg_ready
);
  import css_pkg::*;

  // no result survives a reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result visible after reset");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_found)
      && $stable(out_match_offset) && $stable(out_too_long))
    else $error("pending result changed");

  // a miss reports offset zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_found |-> out_match_offset == '0)
    else $error("offset nonzero on a miss");

  // the input side fills only after a push
  a_full_after_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_full) |-> $past(in_push))
    else $error("input full without a push");

  // configuration never back-pressures
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration port stalled");

endmodule

bind caseless_substring_search css_checker u_css_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_push          (in_push),
  .in_full          (in_full),
  .out_empty        (out_empty),
  .out_pop          (out_pop),
  .out_found        (out_found),
  .out_match_offset (out_match_offset),
  .out_too_long     (out_too_long),
  .cfg_ready        (cfg_ready)
);

`default_nettype wire

/* test/tb_caseless_substring_search.sv */
// Self-checking testbench for caseless_substring_search: streams haystacks through the
// queue ports, predicts the found flag, first offset and overflow flag for each one.
// Depends on css_pkg and the caseless_substring_search RTL.
`default_nettype none

class match_scoreboard;
  logic [63:0] needle_word [4];
  logic [5:0]  needle_len;
  logic [31:0] partial;
  logic [15:0] bytes_taken;
  logic        seen;
  logic [15:0] first_at;
  logic        overflowed;
  css_pkg::css_result_t awaited_results [$];
  int errors;

  function new();
    for (int i = 0; i < 4; i++) needle_word[i] = '0;
    needle_len = '0;
    errors = 0;
    clear_search();
  endfunction

  function void clear_search();
    partial = '0;
    bytes_taken = '0;
    seen = 1'b0;
    first_at = '0;
    overflowed = 1'b0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [63:0] d);
    case (idx)
      css_pkg::CFG_NEEDLE_WORD_0: needle_word[0] = d;
      css_pkg::CFG_NEEDLE_WORD_1: needle_word[1] = d;
      css_pkg::CFG_NEEDLE_WORD_2: needle_word[2] = d;
      css_pkg::CFG_NEEDLE_WORD_3: needle_word[3] = d;
      css_pkg::CFG_NEEDLE_LENGTH: needle_len = d[5:0];
      default: ;
    endcase
  endfunction

  function logic [7:0] to_lower(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  // Work out the state after one accepted byte; queue a result on the last one.
  function void take_byte(logic [7:0] hb, logic is_last);
    logic [7:0]  c;
    int unsigned len;
    logic [31:0] len_mask;
    logic [31:0] eq;
    css_pkg::css_result_t r;
    c = to_lower(hb);
    len = (needle_len > 6'd32) ? 32 : needle_len;
    len_mask = (len >= 32) ? 32'hFFFF_FFFF : (32'd1 << len) - 32'd1;
    if (bytes_taken == 16'hFFFF) begin
      overflowed = 1'b1;
    end else begin
      eq = '0;
      for (int i = 0; i < len; i++) begin
        if (to_lower(needle_word[i >> 3][(i & 7) * 8 +: 8]) == c) eq[i] = 1'b1;
      end
      partial = ((partial << 1) | 32'd1) & eq & len_mask;
      if (len > 0 && !seen && partial[len - 1]) begin
        seen = 1'b1;
        first_at = bytes_taken + 16'd1 - 16'(len);
      end
      bytes_taken = bytes_taken + 16'd1;
    end
    if (is_last) begin
      r.found = (len == 0) ? 1'b1 : seen;
      r.offset = (len != 0 && seen) ? first_at : 16'd0;
      r.too_long = overflowed;
      awaited_results.push_back(r);
      clear_search();
    end
  endfunction

  task report(string msg);
    if (errors < 100) $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  task check_result(logic found, logic [15:0] offset, logic too_long);
    css_pkg::css_result_t want;
    if (awaited_results.size() == 0) begin
      report("result arrived with none outstanding");
      return;
    end
    want = awaited_results.pop_front();
    if (found !== want.found)
      report($sformatf("found %b, want %b", found, want.found));
    if (offset !== want.offset)
      report($sformatf("match_offset %0d, want %0d", offset, want.offset));
    if (too_long !== want.too_long)
      report($sformatf("too_long %b, want %b", too_long, want.too_long));
  endtask
endclass

module tb_caseless_substring_search;
  import css_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_push = 1'b0;
  logic                 in_full;
  logic [BYTE_W-1:0]    in_haystack_byte = 8'h01;
  logic                 in_is_last = 1'b0;
  logic                 out_empty;
  logic                 out_pop = 1'b0;
  logic                 out_found;
  logic [COUNT_W-1:0]   out_match_offset;
  logic                 out_too_long;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_NEEDLE_WORD_0;
  logic [WORD_W-1:0]    cfg_data = '0;

  match_scoreboard sb = new();

  int push_idle_pct = 0;
  int pop_stall_pct = 0;
  int pop_hold_cycles = 0;

  logic [255:0] needle;
  int           needle_len;
  logic [7:0]   hay [$];

  caseless_substring_search DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_haystack_byte (in_haystack_byte),
    .in_is_last       (in_is_last),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_found        (out_found),
    .out_match_offset (out_match_offset),
    .out_too_long     (out_too_long),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #1 clk = ~clk;

  // Result side: pop at random, or hold off for a counted stretch on request.
  initial begin : result_drain
    wait (rst_n === 1'b1);
    forever begin
      if (pop_hold_cycles > 0) begin
        out_pop <= 1'b0;
        repeat (pop_hold_cycles) @(posedge clk);
        pop_hold_cycles = 0;
      end else begin
        out_pop <= (pop_stall_pct == 0) || ($urandom_range(99) >= pop_stall_pct);
        @(posedge clk);
        if (out_pop && !out_empty) sb.check_result(out_found, out_match_offset, out_too_long);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    while (push_idle_pct != 0 && $urandom_range(99) < push_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_haystack_byte <= b;
    in_is_last <= is_last;
    do @(posedge clk); while (in_full);
    sb.take_byte(b, is_last);
  endtask

  task automatic send_haystack();
    foreach (hay[i]) send_byte(hay[i], i == hay.size() - 1);
  endtask

  // Drop push, wait for every outstanding result, then let the pipeline settle.
  task automatic quiesce();
    in_push <= 1'b0;
    do @(posedge clk); while (sb.awaited_results.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, d);
  endtask

  task automatic load_needle(input logic [255:0] nd, input int len);
    logic [63:0] len_word;
    needle = nd;
    needle_len = len;
    len_word = {$urandom, $urandom};
    len_word[5:0] = 6'(len);
    write_reg(CFG_NEEDLE_WORD_0, nd[63:0]);
    write_reg(CFG_NEEDLE_WORD_1, nd[127:64]);
    write_reg(CFG_NEEDLE_WORD_2, nd[191:128]);
    write_reg(CFG_NEEDLE_WORD_3, nd[255:192]);
    // unmapped indexes must leave the needle alone
    if ($urandom_range(3) == 0)
      write_reg(CFG_NEEDLE_LENGTH + 3'd1 + 3'($urandom_range(2)), {$urandom, $urandom});
    write_reg(CFG_NEEDLE_LENGTH, len_word);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [255:0] random_bits();
    logic [255:0] v;
    for (int i = 0; i < 8; i++) v[32 * i +: 32] = $urandom;
    return v;
  endfunction

  function automatic logic [7:0] vary_case(logic [7:0] b);
    if ((b | 8'h20) >= 8'h61 && (b | 8'h20) <= 8'h7A && $urandom_range(1) == 1)
      return b ^ 8'h20;
    return b;
  endfunction

  // Needle from a narrow alphabet (heavy overlap), any byte, or plain letters.
  function automatic logic [255:0] make_needle(int len);
    logic [255:0] nd;
    int           style;
    logic [7:0]   b;
    nd = random_bits();
    style = $urandom_range(2);
    for (int i = 0; i < len; i++) begin
      case (style)
        0: b = vary_case(8'h61 + 8'($urandom_range(1)));
        1: b = 8'($urandom_range(255));
        default: b = vary_case(8'h61 + 8'($urandom_range(25)));
      endcase
      nd[8 * i +: 8] = b;
    end
    return nd;
  endfunction

  function automatic logic [7:0] hay_safe(logic [7:0] b);
    return (b == 8'h00) ? 8'($urandom_range(1, 255)) : vary_case(b);
  endfunction

  // Mix whole needle copies, broken prefixes and loose bytes.
  task automatic fill_haystack(input int max_len);
    int target;
    int pick;
    int cut;
    hay.delete();
    target = $urandom_range(1, max_len);
    while (hay.size() < target) begin
      pick = $urandom_range(99);
      if (needle_len > 0 && pick < 25) begin
        for (int i = 0; i < needle_len; i++) hay.push_back(hay_safe(needle[8 * i +: 8]));
      end else if (needle_len > 1 && pick < 45) begin
        cut = $urandom_range(1, needle_len - 1);
        for (int i = 0; i < cut; i++) hay.push_back(hay_safe(needle[8 * i +: 8]));
      end else if (needle_len > 0 && pick < 75) begin
        hay.push_back(hay_safe(needle[8 * $urandom_range(needle_len - 1) +: 8]));
      end else begin
        hay.push_back(8'($urandom_range(1, 255)));
      end
    end
  endtask

  task automatic directed_run();
    logic [255:0] nd;
    quiesce();
    load_needle(random_bits(), 0);
    hay = {8'hFF};
    send_haystack();
    // letters at both case edges, punctuation next to them, a high byte that must not fold
    quiesce();
    nd = random_bits();
    nd[23:0] = 24'hC1_5A_61;
    load_needle(nd, 3);
    hay = {8'h01, 8'h41, 8'h41, 8'h7A, 8'hE1, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'h80,
           8'h41, 8'h5A, 8'hC1, 8'h61, 8'h7A, 8'hC1, 8'hFF};
    send_haystack();
    // a zero needle byte can never meet a haystack byte
    quiesce();
    nd = random_bits();
    nd[15:0] = 16'h00_62;
    load_needle(nd, 2);
    hay = {8'h62, 8'h62, 8'h01};
    send_haystack();
    quiesce();
    nd = random_bits();
    nd[7:0] = 8'h51;
    load_needle(nd, 1);
    hay = {8'h71};
    send_haystack();
    quiesce();
  endtask

  initial begin : stimulus
    int sent;
    int len;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_run();
    for (int phase = 0; phase < 16; phase++) begin
      case (phase % 4)
        0: begin push_idle_pct = 0;  pop_stall_pct = 0;  end
        1: begin push_idle_pct = 76; pop_stall_pct = 0;  end
        2: begin push_idle_pct = 0;  pop_stall_pct = 76; end
        default: begin push_idle_pct = 19; pop_stall_pct = 19; end
      endcase
      case (phase)
        1, 4: len = 32;
        2: len = 1;
        3: len = 0;
        default: len = ($urandom_range(3) == 0) ? $urandom_range(0, 32) : $urandom_range(1, 8);
      endcase
      load_needle(make_needle(len), len);
      // hold the result side while short haystacks keep coming, so the queue backs up
      if (phase == 6) pop_hold_cycles = 300;
      sent = 0;
      while (sent < 50) begin
        fill_haystack((phase == 6) ? 3 : 40);
        send_haystack();
        sent += hay.size();
      end
      quiesce();
    end
    if (sb.errors == 0) begin
      $display("tb_caseless_substring_search: clean");
    end else begin
      $display("tb_caseless_substring_search: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("tb_caseless_substring_search: errors");
    $finish;
  end

endmodule

`default_nettype wire
